// ===== rtl/wpd_pkg.sv =====
// ----------------------------------------------------------------------------
// wpd_pkg
// Shared types and constants for the WAV PCM to DAC sample parser.
// ----------------------------------------------------------------------------
package wpd_pkg;

	// result kinds
	localparam logic [1:0] EV_START  = 2'd0;
	localparam logic [1:0] EV_SAMPLE = 2'd1;
	localparam logic [1:0] EV_END    = 2'd2;
	localparam logic [1:0] EV_REJECT = 2'd3;

	// chunk tags, first byte in the top lane
	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam logic [31:0] FMT_MIN_LEN = 32'd16;
	localparam logic [15:0] PCM_TAG     = 16'd1;
	localparam logic [7:0]  DAC_MID     = 8'd128;

	// result queue: one byte makes at most two results
	localparam int EVQ_DEPTH = 4;
	localparam int EVQ_AW    = $clog2(EVQ_DEPTH);

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  sample;
		logic [31:0] rate;
		logic        last;
	} event_t;

endpackage

// ===== rtl/wpd_byte_if.sv =====
// ----------------------------------------------------------------------------
// wpd_byte_if
// Byte request channel: one file byte plus its end-of-file mark.
// ----------------------------------------------------------------------------
interface wpd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_file;

	modport source (output valid, output data_byte, output end_of_file, input ready);
	modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

// ===== rtl/wpd_event_if.sv =====
// ----------------------------------------------------------------------------
// wpd_event_if
// Result request channel: stream start, sample, stream end or reject.
// ----------------------------------------------------------------------------
interface wpd_event_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_kind;
	logic [7:0]  dac_sample;
	logic [31:0] stream_rate;
	logic        last_of_run;

	modport source (output valid, output event_kind, output dac_sample, output stream_rate,
		output last_of_run, input ready);
	modport sink   (input valid, input event_kind, input dac_sample, input stream_rate,
		input last_of_run, output ready);
endinterface

// ===== rtl/wav_pcm_stream_to_dac_samples_unit.sv =====
// ----------------------------------------------------------------------------
// wav_pcm_stream_to_dac_samples_unit
// Parses a RIFF/WAVE file byte by byte and turns its PCM data chunk into
// stream start, 8-bit DAC samples (first channel) and stream end, or a reject.
// ----------------------------------------------------------------------------
//  channel     dir   request payload
//  file_bytes  in    data_byte[7:0], end_of_file
//  events      out   event_kind[1:0], dac_sample[7:0], stream_rate[31:0], last_of_run
//
//  One byte per cycle sustained while the queue has room: a byte is held in the
//  input stage, the parser updates its state and pushes up to two results into a
//  4-entry queue, from which a byte's first result is then offered.
//  The input stage advances while the queue has room for two results, so a
//  stalled sink backs up into file_bytes.ready once fewer than two entries are free.
//  arst_n clears parser state and the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module wav_pcm_stream_to_dac_samples_unit (
	input  logic               clk,
	input  logic               arst_n,
	wpd_byte_if.sink           file_bytes,
	wpd_event_if.source        events
);

	typedef enum logic [2:0] {
		PH_HDR,
		PH_CHDR,
		PH_FMT,
		PH_SKIP,
		PH_DATA,
		PH_WAIT
	} phase_t;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;

	// parser state
	phase_t      phase_q, phase_n;
	logic [4:0]  group_q, group_n;
	logic [31:0] tag_q, tag_n;
	logic [31:0] clen_q, clen_n;
	logic [32:0] skip_q, skip_n;
	logic        fmt_seen_q, fmt_seen_n;
	logic [15:0] chans_q, chans_n;
	logic [15:0] bits_q, bits_n;
	logic [31:0] rate_q, rate_n;
	logic [31:0] data_left_q, data_left_n;
	logic [16:0] frame_pos_q, frame_pos_n;
	logic [7:0]  first_low_q, first_low_n;

	// results of the current byte
	wpd_pkg::event_t ev0, ev1;
	logic [1:0]      ev_cnt;

	// result queue
	wpd_pkg::event_t                evq_q [wpd_pkg::EVQ_DEPTH];
	logic [wpd_pkg::EVQ_AW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [wpd_pkg::EVQ_AW:0]       count_q;

	logic advance;
	logic pop;

	assign advance = valid_s1 && (count_q <= (wpd_pkg::EVQ_AW+1)'(wpd_pkg::EVQ_DEPTH - 2));
	assign pop     = events.valid && events.ready;

	assign file_bytes.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (file_bytes.ready) begin
			valid_s1 <= file_bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (file_bytes.valid && file_bytes.ready) begin
			byte_s1 <= file_bytes.data_byte;
			eof_s1  <= file_bytes.end_of_file;
		end
	end

	// next-state and result logic for the byte in the input stage
	always_comb begin
		logic        reject;
		logic [31:0] tag_sh;
		logic [32:0] skip_amt;
		logic        go_skip;
		logic        data_ok;
		logic [16:0] stride;
		logic [16:0] fp_inc;
		logic [7:0]  q;

		phase_n     = phase_q;
		group_n     = group_q;
		tag_n       = tag_q;
		clen_n      = clen_q;
		skip_n      = skip_q;
		fmt_seen_n  = fmt_seen_q;
		chans_n     = chans_q;
		bits_n      = bits_q;
		rate_n      = rate_q;
		data_left_n = data_left_q;
		frame_pos_n = frame_pos_q;
		first_low_n = first_low_q;

		ev0    = '0;
		ev1    = '0;
		ev_cnt = 2'd0;

		reject   = 1'b0;
		go_skip  = 1'b0;
		skip_amt = '0;
		tag_sh   = {tag_q[23:0], byte_s1};
		data_ok  = fmt_seen_q && (rate_q != 32'd0) && (chans_q != 16'd0) &&
			(bits_q == 16'd8 || bits_q == 16'd16);
		stride   = bits_q[4] ? {chans_q, 1'b0} : {1'b0, chans_q};
		fp_inc   = frame_pos_q + 17'd1;
		q        = '0;

		unique case (phase_q)
			PH_HDR: begin
				tag_n = tag_sh;
				if (group_q == 5'd3 && tag_sh != wpd_pkg::TAG_RIFF) begin
					clen_n = 32'd1;
				end
				if (group_q >= 5'd11) begin
					if (clen_n != 32'd0 || tag_sh != wpd_pkg::TAG_WAVE || eof_s1) begin
						reject = 1'b1;
					end else begin
						go_skip = 1'b1;
					end
				end else begin
					group_n = group_q + 5'd1;
					reject  = eof_s1;
				end
			end
			PH_CHDR: begin
				if (group_q < 5'd4) begin
					tag_n = tag_sh;
					if (group_q == 5'd0) begin
						clen_n = '0;
					end
				end else begin
					unique case (group_q[1:0])
						2'd0: clen_n[7:0]   = clen_q[7:0]   | byte_s1;
						2'd1: clen_n[15:8]  = clen_q[15:8]  | byte_s1;
						2'd2: clen_n[23:16] = clen_q[23:16] | byte_s1;
						2'd3: clen_n[31:24] = clen_q[31:24] | byte_s1;
						default: ;
					endcase
				end
				if (group_q < 5'd7) begin
					group_n = group_q + 5'd1;
					reject  = eof_s1;
				end else begin
					group_n = '0;
					if (tag_n == wpd_pkg::TAG_FMT) begin
						if (clen_n < wpd_pkg::FMT_MIN_LEN || eof_s1) begin
							reject = 1'b1;
						end else begin
							tag_n   = '0;
							phase_n = PH_FMT;
						end
					end else if (tag_n == wpd_pkg::TAG_DATA) begin
						if (!data_ok) begin
							reject = 1'b1;
						end else if (eof_s1 || clen_n == 32'd0) begin
							phase_n = PH_WAIT;
						end else begin
							ev0.kind    = wpd_pkg::EV_START;
							ev0.rate    = rate_q;
							ev_cnt      = 2'd1;
							data_left_n = clen_n;
							frame_pos_n = '0;
							phase_n     = PH_DATA;
						end
					end else if (eof_s1) begin
						reject = 1'b1;
					end else begin
						go_skip  = 1'b1;
						skip_amt = {1'b0, clen_n} + {32'd0, clen_n[0]};
					end
				end
			end
			PH_FMT: begin
				unique case (group_q)
					5'd0:    tag_n = {24'd0, byte_s1};
					5'd1:    tag_n = {16'd0, byte_s1, tag_q[7:0]};
					5'd2:    chans_n = {8'd0, byte_s1};
					5'd3:    chans_n = {byte_s1, chans_q[7:0]};
					5'd4:    rate_n = {24'd0, byte_s1};
					5'd5:    rate_n[15:8] = byte_s1;
					5'd6:    rate_n[23:16] = byte_s1;
					5'd7:    rate_n[31:24] = byte_s1;
					5'd14:   bits_n = {8'd0, byte_s1};
					5'd15:   bits_n = {byte_s1, bits_q[7:0]};
					default: ;
				endcase
				if (group_q < 5'd15) begin
					group_n = group_q + 5'd1;
					reject  = eof_s1;
				end else if (tag_q != {16'd0, wpd_pkg::PCM_TAG} || eof_s1) begin
					reject = 1'b1;
				end else begin
					fmt_seen_n = 1'b1;
					go_skip    = 1'b1;
					skip_amt   = {1'b0, clen_q - wpd_pkg::FMT_MIN_LEN} + {32'd0, clen_q[0]};
				end
			end
			PH_SKIP: begin
				if (skip_q != 33'd0) begin
					skip_n = skip_q - 33'd1;
				end
				if (eof_s1) begin
					reject = 1'b1;
				end else if (skip_n == 33'd0) begin
					go_skip = 1'b1;
				end
			end
			PH_DATA: begin
				if (frame_pos_q == 17'd0) begin
					first_low_n = byte_s1;
				end else if (bits_q[4] && frame_pos_q == 17'd1) begin
					// signed word / 256 toward zero, then recenter
					q = byte_s1 + {7'd0, byte_s1[7] && first_low_q != 8'd0};
					first_low_n = q + wpd_pkg::DAC_MID;
				end
				frame_pos_n = fp_inc;
				if (fp_inc >= stride) begin
					ev0.kind    = wpd_pkg::EV_SAMPLE;
					ev0.sample  = first_low_n;
					ev_cnt      = 2'd1;
					frame_pos_n = '0;
				end
				if (data_left_q != 32'd0) begin
					data_left_n = data_left_q - 32'd1;
				end
				if (data_left_n == 32'd0 || eof_s1) begin
					if (ev_cnt == 2'd0) begin
						ev0.kind = wpd_pkg::EV_END;
					end else begin
						ev1.kind = wpd_pkg::EV_END;
					end
					ev_cnt  = ev_cnt + 2'd1;
					phase_n = PH_WAIT;
				end
			end
			PH_WAIT: ;
			default: ;
		endcase

		if (go_skip) begin
			group_n = '0;
			tag_n   = '0;
			clen_n  = '0;
			skip_n  = skip_amt;
			phase_n = (skip_amt != 33'd0) ? PH_SKIP : PH_CHDR;
		end

		// a reject never shares its byte with another result
		if (reject) begin
			ev0.kind = wpd_pkg::EV_REJECT;
			ev_cnt   = 2'd1;
			phase_n  = PH_WAIT;
		end

		if (eof_s1) begin
			phase_n     = PH_HDR;
			group_n     = '0;
			tag_n       = '0;
			clen_n      = '0;
			skip_n      = '0;
			fmt_seen_n  = 1'b0;
			chans_n     = '0;
			bits_n      = '0;
			rate_n      = '0;
			data_left_n = '0;
			frame_pos_n = '0;
			first_low_n = '0;
		end

		if (ev_cnt == 2'd2) begin
			ev1.last = 1'b1;
		end else begin
			ev0.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HDR;
			group_q     <= '0;
			tag_q       <= '0;
			clen_q      <= '0;
			skip_q      <= '0;
			fmt_seen_q  <= 1'b0;
			chans_q     <= '0;
			bits_q      <= '0;
			rate_q      <= '0;
			data_left_q <= '0;
			frame_pos_q <= '0;
			first_low_q <= '0;
		end else if (advance) begin
			phase_q     <= phase_n;
			group_q     <= group_n;
			tag_q       <= tag_n;
			clen_q      <= clen_n;
			skip_q      <= skip_n;
			fmt_seen_q  <= fmt_seen_n;
			chans_q     <= chans_n;
			bits_q      <= bits_n;
			rate_q      <= rate_n;
			data_left_q <= data_left_n;
			frame_pos_q <= frame_pos_n;
			first_low_q <= first_low_n;
		end
	end

	// result queue
	always_ff @(posedge clk) begin
		if (advance && ev_cnt != 2'd0) begin
			evq_q[wr_ptr_q] <= ev0;
			if (ev_cnt == 2'd2) begin
				evq_q[wr_ptr_q + wpd_pkg::EVQ_AW'(1)] <= ev1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (advance) begin
				wr_ptr_q <= wr_ptr_q + wpd_pkg::EVQ_AW'(ev_cnt);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + wpd_pkg::EVQ_AW'(1);
			end
			count_q <= count_q + (advance ? (wpd_pkg::EVQ_AW+1)'(ev_cnt) : '0)
				- (wpd_pkg::EVQ_AW+1)'(pop);
		end
	end

	assign events.valid       = (count_q != '0);
	assign events.event_kind  = evq_q[rd_ptr_q].kind;
	assign events.dac_sample  = evq_q[rd_ptr_q].sample;
	assign events.stream_rate = evq_q[rd_ptr_q].rate;
	assign events.last_of_run = evq_q[rd_ptr_q].last;

endmodule

// ===== rtl/wpd_checker.sv =====
// ----------------------------------------------------------------------------
// wpd_checker
// Port-level checks on the result channel of the WAV parser.
// ----------------------------------------------------------------------------
module wpd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        ev_valid,
	input logic        ev_ready,
	input logic [1:0]  event_kind,
	input logic [7:0]  dac_sample,
	input logic [31:0] stream_rate,
	input logic        last_of_run
);

	// held request keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && !ev_ready |=> ev_valid && $stable(event_kind) && $stable(dac_sample) &&
		$stable(stream_rate) && $stable(last_of_run))
		else $error("result request dropped or changed while stalled");

	// start, end and reject always close the run of their byte
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && (event_kind == wpd_pkg::EV_START || event_kind == wpd_pkg::EV_END ||
		event_kind == wpd_pkg::EV_REJECT) |-> last_of_run)
		else $error("start/end/reject without last_of_run");

	a_rate: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && event_kind != wpd_pkg::EV_START |-> stream_rate == 32'd0)
		else $error("rate set on a non-start result");

	a_sample: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && event_kind != wpd_pkg::EV_SAMPLE |-> dac_sample == 8'd0)
		else $error("sample set on a non-sample result");

endmodule

bind wav_pcm_stream_to_dac_samples_unit wpd_checker u_wpd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.ev_valid    (events.valid),
	.ev_ready    (events.ready),
	.event_kind  (events.event_kind),
	.dac_sample  (events.dac_sample),
	.stream_rate (events.stream_rate),
	.last_of_run (events.last_of_run)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Feeds WAV files, well formed, damaged, cut short and plain noise, one byte per
// request into the parser and checks every start, sample, end and reject
// result against a byte-level model of the parser kept in a scoreboard.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD      = 250;
	localparam int END_DRAIN      = 20;
	localparam int TOTAL_BYTES    = 450;

	typedef logic [7:0] byte_q_t[$];

	typedef enum logic [2:0] {
		PH_HEADER, PH_CHUNK_HDR, PH_FMT_BODY, PH_SKIP, PH_DATA, PH_DRAIN
	} parse_phase_t;

	typedef enum int {
		FLAW_NONE, FLAW_MAGIC, FLAW_SHORT_FMT, FLAW_FMT_TAG, FLAW_NO_FMT
	} flaw_t;

	class wav_scoreboard;
		parse_phase_t    phase;
		logic [4:0]      group;
		logic [31:0]     tag;
		logic [31:0]     chunk_len;
		logic [32:0]     skip_left;
		logic            fmt_ok;
		logic [15:0]     channels;
		logic [15:0]     bits;
		logic [31:0]     rate;
		logic [31:0]     data_left;
		logic [16:0]     frame_pos;
		logic [7:0]      first_low;
		wpd_pkg::event_t expected_q[$];
		int              failures;

		function new();
			clear_file();
			failures = 0;
		endfunction

		function void clear_file();
			phase = PH_HEADER;
			group = '0;
			tag = '0;
			chunk_len = '0;
			skip_left = '0;
			fmt_ok = 1'b0;
			channels = '0;
			bits = '0;
			rate = '0;
			data_left = '0;
			frame_pos = '0;
			first_low = '0;
		endfunction

		function void go_skip(input logic [32:0] amount);
			group = '0;
			tag = '0;
			chunk_len = '0;
			skip_left = amount;
			phase = (amount != 0) ? PH_SKIP : PH_CHUNK_HDR;
		endfunction

		function wpd_pkg::event_t make_event(input logic [1:0] kind, input logic [7:0] dac,
				input logic [31:0] hz);
			wpd_pkg::event_t e;
			e.kind = kind;
			e.sample = dac;
			e.rate = hz;
			e.last = 1'b0;
			return e;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_byte(input logic [7:0] b, input logic eof);
			wpd_pkg::event_t made[$];
			bit              reject;
			bit              fmt_valid;
			logic [31:0]     stride;
			logic [8:0]      q;
			reject = 1'b0;
			case (phase)
				PH_HEADER: begin
					tag = {tag[23:0], b};
					// bit 0 of the length flags a bad RIFF tag until byte twelve
					if (group == 5'd3 && tag != wpd_pkg::TAG_RIFF)
						chunk_len = 32'd1;
					if (group >= 5'd11) begin
						if (chunk_len != 0 || tag != wpd_pkg::TAG_WAVE || eof)
							reject = 1'b1;
						else
							go_skip('0);
					end else begin
						group++;
						if (eof)
							reject = 1'b1;
					end
				end
				PH_CHUNK_HDR: begin
					if (group < 5'd4) begin
						tag = {tag[23:0], b};
						if (group == 5'd0)
							chunk_len = '0;
					end else begin
						chunk_len = chunk_len | (32'(b) << (8 * group[1:0]));
					end
					if (group < 5'd7) begin
						group++;
						if (eof)
							reject = 1'b1;
					end else begin
						group = '0;
						if (tag == wpd_pkg::TAG_FMT) begin
							if (chunk_len < wpd_pkg::FMT_MIN_LEN || eof) begin
								reject = 1'b1;
							end else begin
								tag = '0;
								phase = PH_FMT_BODY;
							end
						end else if (tag == wpd_pkg::TAG_DATA) begin
							fmt_valid = fmt_ok && rate != 0 && channels != 0 &&
								(bits == 16'd8 || bits == 16'd16);
							if (!fmt_valid) begin
								reject = 1'b1;
							end else if (eof || chunk_len == 0) begin
								phase = PH_DRAIN;
							end else begin
								made.push_back(make_event(wpd_pkg::EV_START, 8'd0, rate));
								data_left = chunk_len;
								frame_pos = '0;
								phase = PH_DATA;
							end
						end else begin
							if (eof)
								reject = 1'b1;
							else
								go_skip({1'b0, chunk_len} + 33'(chunk_len[0]));
						end
					end
				end
				PH_FMT_BODY: begin
					case (group)
						5'd0: tag = {24'd0, b};
						5'd1: tag = tag | (32'(b) << 8);
						5'd2: channels = {8'd0, b};
						5'd3: channels = channels | (16'(b) << 8);
						5'd4: rate = {24'd0, b};
						5'd5, 5'd6, 5'd7: rate = rate | (32'(b) << (8 * (group - 5'd4)));
						5'd14: bits = {8'd0, b};
						5'd15: bits = bits | (16'(b) << 8);
						default: ;
					endcase
					if (group < 5'd15) begin
						group++;
						if (eof)
							reject = 1'b1;
					end else if (tag != 32'(wpd_pkg::PCM_TAG) || eof) begin
						reject = 1'b1;
					end else begin
						fmt_ok = 1'b1;
						go_skip({1'b0, chunk_len - wpd_pkg::FMT_MIN_LEN} + 33'(chunk_len[0]));
					end
				end
				PH_SKIP: begin
					if (skip_left != 0)
						skip_left--;
					if (eof)
						reject = 1'b1;
					else if (skip_left == 0)
						go_skip('0);
				end
				PH_DATA: begin
					stride = 32'(bits >> 3) * 32'(channels);
					if (frame_pos == 0) begin
						first_low = b;
					end else if ((bits >> 3) == 16'd2 && frame_pos == 17'd1) begin
						// signed 16-bit / 256, rounded toward zero, then offset
						q = {1'b0, b};
						if (b[7] && first_low != 0)
							q++;
						first_low = q[7:0] + wpd_pkg::DAC_MID;
					end
					frame_pos = frame_pos + 17'd1;
					if (32'(frame_pos) >= stride) begin
						made.push_back(make_event(wpd_pkg::EV_SAMPLE, first_low, 32'd0));
						frame_pos = '0;
					end
					if (data_left != 0)
						data_left--;
					if (data_left == 0 || eof) begin
						made.push_back(make_event(wpd_pkg::EV_END, 8'd0, 32'd0));
						phase = PH_DRAIN;
					end
				end
				default: ;
			endcase
			if (reject) begin
				made.push_back(make_event(wpd_pkg::EV_REJECT, 8'd0, 32'd0));
				phase = PH_DRAIN;
			end
			if (eof)
				clear_file();
			if (made.size() > 0)
				made[made.size() - 1].last = 1'b1;
			foreach (made[i])
				expected_q.push_back(made[i]);
		endfunction

		function bit field_bad(input string name, input logic [31:0] want, input logic [31:0] got);
			if (want === got)
				return 1'b0;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			return 1'b1;
		endfunction

		function void check_event(input logic [1:0] kind, input logic [7:0] dac,
				input logic [31:0] hz, input logic last);
			wpd_pkg::event_t want;
			bit              bad;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual kind %0h sample %0h rate %0h last %0b",
					$time, kind, dac, hz, last);
				failures++;
				return;
			end
			want = expected_q.pop_front();
			bad = field_bad("event_kind", 32'(want.kind), 32'(kind));
			bad |= field_bad("dac_sample", 32'(want.sample), 32'(dac));
			bad |= field_bad("stream_rate", want.rate, hz);
			bad |= field_bad("last_of_run", 32'(want.last), 32'(last));
			if (bad)
				failures++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	wpd_byte_if  file_bytes_if();
	wpd_event_if events_if();

	wav_pcm_stream_to_dac_samples_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.file_bytes (file_bytes_if),
		.events     (events_if)
	);

	wav_scoreboard sb = new();

	bit calm = 1'b0;
	int hold_asks = 0;
	int hold_done = 0;
	int stall_left = 0;
	int idle_cycles = 0;
	int bytes_sent = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result side: check, then choose ready for the next cycle
	always @(posedge clk) begin
		if (events_if.valid && events_if.ready)
			sb.check_event(events_if.event_kind, events_if.dac_sample,
				events_if.stream_rate, events_if.last_of_run);
		if (hold_done != hold_asks) begin
			hold_done = hold_asks;
			stall_left = LONG_HOLD;
		end else if (stall_left == 0 && !calm && $urandom_range(0, 99) < 15) begin
			stall_left = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(8, 40);
		end
		if (stall_left > 0) begin
			events_if.ready <= 1'b0;
			stall_left--;
		end else begin
			events_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((file_bytes_if.valid && file_bytes_if.ready) || (events_if.valid && events_if.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no request moved for %0d cycles", $time, idle_cycles);
			$display("testbench NOT OK");
			$finish;
		end
	end

	function automatic void push_le(ref byte_q_t f, input logic [31:0] v, input int n);
		for (int i = 0; i < n; i++)
			f.push_back(v[8 * i +: 8]);
	endfunction

	function automatic void push_tag(ref byte_q_t f, input logic [31:0] v);
		for (int i = 3; i >= 0; i--)
			f.push_back(v[8 * i +: 8]);
	endfunction

	function automatic byte_q_t random_bytes(input int n);
		byte_q_t r;
		repeat (n)
			r.push_back(8'($urandom));
		return r;
	endfunction

	// unknown chunk; bodies of huge ones are left to the eof cut
	function automatic void push_junk(ref byte_q_t f, input logic [31:0] len);
		logic [31:0] t;
		t = $urandom;
		if (t == wpd_pkg::TAG_FMT || t == wpd_pkg::TAG_DATA)
			t ^= 32'd1;
		push_tag(f, t);
		push_le(f, len, 4);
		if (len <= 64) begin
			repeat (len)
				f.push_back(8'($urandom));
			if (len[0])
				f.push_back(8'($urandom));
		end
	endfunction

	function automatic void build_wav(ref byte_q_t f, input flaw_t flaw, input logic [15:0] chans,
			input logic [15:0] depth, input logic [31:0] hz, input logic [31:0] fmt_len,
			input longint junk_len, input bit junk_after, input logic [31:0] data_len,
			input byte_q_t body);
		int          pos;
		logic [31:0] len;
		logic [31:0] ftag;
		f.delete();
		push_tag(f, wpd_pkg::TAG_RIFF);
		push_le(f, $urandom, 4);
		push_tag(f, wpd_pkg::TAG_WAVE);
		if (flaw == FLAW_MAGIC) begin
			pos = $urandom_range(0, 7);
			if (pos >= 4)
				pos += 4;
			f[pos] ^= 8'($urandom_range(1, 255));
		end
		if (junk_len >= 0)
			push_junk(f, 32'(junk_len));
		if (flaw != FLAW_NO_FMT) begin
			len = (flaw == FLAW_SHORT_FMT) ? 32'($urandom_range(0, 15)) : fmt_len;
			ftag = 32'(wpd_pkg::PCM_TAG);
			if (flaw == FLAW_FMT_TAG) begin
				ftag = $urandom_range(0, 65535);
				if (ftag == 32'(wpd_pkg::PCM_TAG))
					ftag = 32'd0;
			end
			push_tag(f, wpd_pkg::TAG_FMT);
			push_le(f, len, 4);
			push_le(f, ftag, 2);
			push_le(f, 32'(chans), 2);
			push_le(f, hz, 4);
			push_le(f, $urandom, 4);
			push_le(f, $urandom, 2);
			push_le(f, 32'(depth), 2);
			if (len > 16) begin
				repeat (len - 16)
					f.push_back(8'($urandom));
				if (len[0])
					f.push_back(8'($urandom));
			end
		end
		if (junk_after)
			push_junk(f, $urandom_range(0, 6));
		push_tag(f, wpd_pkg::TAG_DATA);
		push_le(f, data_len, 4);
		foreach (body[i])
			f.push_back(body[i]);
	endfunction

	function automatic void cut_file(ref byte_q_t f, input int keep);
		while (f.size() > keep)
			void'(f.pop_back());
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic eof);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			file_bytes_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		file_bytes_if.valid <= 1'b1;
		file_bytes_if.data_byte <= b;
		file_bytes_if.end_of_file <= eof;
		do @(posedge clk); while (!file_bytes_if.ready);
		sb.note_byte(b, eof);
		bytes_sent++;
	endtask

	task automatic send_file(input byte_q_t f);
		foreach (f[i])
			send_byte(f[i], i == f.size() - 1);
	endtask

	// data chunk sent back to back while the result side holds off
	task automatic pressure_file();
		byte_q_t f;
		hold_asks++;
		calm = 1'b1;
		build_wav(f, FLAW_NONE, 16'd1, 16'd8, 32'd16000, 32'd16, -1, 1'b0, 32'd40,
			random_bytes(40));
		send_file(f);
		calm = 1'b0;
	endtask

	task automatic run_directed();
		byte_q_t f;
		byte_q_t body;
		int      cuts[2];
		cuts = '{12, 36};
		// 8-bit mono, one sample per byte
		body = {8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01};
		build_wav(f, FLAW_NONE, 16'd1, 16'd8, 32'd8000, 32'd16, -1, 1'b0, 32'd5, body);
		send_file(f);
		// 16-bit stereo: conversion extremes, odd junk, long fmt,
		// partial last frame and stray bytes after the chunk
		body = {8'h00, 8'h80, 8'h11, 8'h22, 8'hFF, 8'h7F, 8'h33, 8'h44,
			8'h80, 8'hFF, 8'h55, 8'h66, 8'h00, 8'h00, 8'h77, 8'h88,
			8'h00, 8'hFF, 8'h99, 8'hAA, 8'hBB, 8'hCC, 8'hDD, 8'hEE, 8'hF0, 8'h0F};
		build_wav(f, FLAW_NONE, 16'd2, 16'd16, 32'hFFFF_FFFF, 32'd18, 5, 1'b0, 32'd23, body);
		send_file(f);
		// bad magic; the file ends right after the reject
		build_wav(f, FLAW_MAGIC, 16'd1, 16'd8, 32'd8000, 32'd16, -1, 1'b0, 32'd4,
			random_bytes(4));
		cut_file(f, 13);
		send_file(f);
		// eof on the last header byte, then at the end of the fmt chunk
		foreach (cuts[i]) begin
			build_wav(f, FLAW_NONE, 16'd1, 16'd8, 32'd22050, 32'd16, -1, 1'b0, 32'd4,
				random_bytes(4));
			cut_file(f, cuts[i]);
			send_file(f);
		end
		// eof deep inside a huge skipped chunk
		build_wav(f, FLAW_NONE, 16'd1, 16'd8, 32'd8000, 32'd16, 64'hFFFF_FFF0, 1'b0, 32'd4,
			random_bytes(4));
		cut_file(f, 30);
		send_file(f);
		// widest frame never completes; maximum data length cut by eof
		build_wav(f, FLAW_NONE, 16'hFFFF, 16'd16, 32'd1, 32'd16, -1, 1'b0, 32'hFFFF_FFFF,
			random_bytes(8));
		send_file(f);
	endtask

	task automatic random_file();
		byte_q_t     f;
		int          pick;
		int          variant;
		int          stride;
		int          data_len;
		int          body_len;
		bit          cut;
		logic [15:0] chans;
		logic [15:0] depth;
		logic [31:0] hz;
		logic [31:0] fmt_len;
		longint      junk_len;
		flaw_t       flaw;
		pick = $urandom_range(0, 99);
		if (pick >= 85) begin
			// noise, half of it behind a valid file header
			if ($urandom_range(0, 1)) begin
				push_tag(f, wpd_pkg::TAG_RIFF);
				push_le(f, $urandom, 4);
				push_tag(f, wpd_pkg::TAG_WAVE);
			end
			repeat ($urandom_range(1, 24))
				f.push_back(8'($urandom));
			send_file(f);
			return;
		end
		chans = 16'($urandom_range(1, 3));
		depth = $urandom_range(0, 1) ? 16'd16 : 16'd8;
		hz = $urandom;
		if (hz == 0)
			hz = 32'd1;
		fmt_len = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(17, 20)) : 32'd16;
		junk_len = ($urandom_range(0, 2) == 0) ? longint'($urandom_range(0, 9)) : -1;
		stride = int'(chans) * int'(depth) / 8;
		data_len = $urandom_range(0, 6) * stride;
		if ($urandom_range(0, 3) == 0)
			data_len += $urandom_range(0, stride - 1);
		variant = $urandom_range(0, 9);
		if (variant < 6)
			body_len = data_len;
		else if (variant < 8)
			body_len = $urandom_range(0, data_len);
		else
			body_len = data_len + $urandom_range(1, 4);
		flaw = FLAW_NONE;
		cut = 1'b0;
		if (pick >= 70) begin
			case ($urandom_range(0, 7))
				0: flaw = FLAW_MAGIC;
				1: flaw = FLAW_SHORT_FMT;
				2: flaw = FLAW_FMT_TAG;
				3: flaw = FLAW_NO_FMT;
				4: begin
					depth = 16'($urandom);
					if (depth == 16'd8 || depth == 16'd16)
						depth = 16'd24;
				end
				5: hz = 32'd0;
				6: chans = 16'd0;
				default: cut = 1'b1;
			endcase
		end
		build_wav(f, flaw, chans, depth, hz, fmt_len, junk_len, $urandom_range(0, 3) == 0,
			32'(data_len), random_bytes(body_len));
		if (cut)
			cut_file(f, $urandom_range(1, f.size()));
		send_file(f);
	endtask

	initial begin
		arst_n <= 1'b0;
		file_bytes_if.valid <= 1'b0;
		file_bytes_if.data_byte <= 8'd0;
		file_bytes_if.end_of_file <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		pressure_file();

		while (bytes_sent < TOTAL_BYTES) begin
			calm = ($urandom_range(0, 4) == 0);
			random_file();
		end
		calm = 1'b0;
		file_bytes_if.valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (END_DRAIN) @(posedge clk);

		if (sb.failures == 0 && sb.pending() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
